// ===== rtl/mrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared widths, codes and the request type of the matrix ring sum block.
// ----------------------------------------------------------------------------
package mrs_pkg;

  // Item field widths.
  localparam int IDX_W       = 5;   // row and column index of an item
  localparam int VALUE_W     = 16;  // sample value carried by a write item
  localparam int OUT_W       = 24;  // ring sum result
  localparam int IN_TDATA_W  = 32;  // row, col, value packed and padded to bytes
  localparam int OUT_TDATA_W = 24;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int SIZE_W     = 6;    // num_rows, num_cols
  localparam int RADIUS_W   = 5;
  localparam int EFF_W      = 7;    // size clipped to the store, holds up to 64

  // Signed ring coordinates: centre plus or minus radius.
  localparam int COORD_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd2;

  localparam logic [SIZE_W-1:0]   RESET_NUM_ROWS = 6'd32;
  localparam logic [SIZE_W-1:0]   RESET_NUM_COLS = 6'd32;
  localparam logic [RADIUS_W-1:0] RESET_RADIUS   = 5'd1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Saturation bounds of the 24-bit signed result.
  localparam int SUM_MAX = 8388607;
  localparam int SUM_MIN = -8388608;

  // One ring cell visit, issued together with its store read address.
  typedef struct packed {
    logic valid;
    logic inb;    // cell lies inside the matrix in use
    logic first;  // first cell of the query
    logic last;   // last cell of the query
  } ring_req_t;

endpackage

// ===== rtl/mrs_store.sv =====
// ----------------------------------------------------------------------------
// mrs_store
// Sample memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mrs_store #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mrs_ring_gen.sv =====
// ----------------------------------------------------------------------------
// mrs_ring_gen
// Walks the cells of one ring, one per cycle, and issues store reads.
// ----------------------------------------------------------------------------
module mrs_ring_gen import mrs_pkg::*; #(
  parameter int AW = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [IDX_W-1:0]    row_i,
  input  logic [IDX_W-1:0]    col_i,
  input  logic [RADIUS_W-1:0] radius_i,
  input  logic [EFF_W-1:0]    eff_rows_i,
  input  logic [EFF_W-1:0]    eff_cols_i,
  output logic [2*AW-1:0]     rd_addr_o,
  output ring_req_t           req_o,
  output logic                busy_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_ROWS, ST_COLS} gen_state_e;

  localparam int J_W = RADIUS_W + 1;

  gen_state_e           state_q;
  logic [IDX_W-1:0]     row_q;
  logic [IDX_W-1:0]     col_q;
  logic [RADIUS_W-1:0]  rad_q;
  logic [J_W-1:0]       j_q;
  logic                 side_q;

  logic signed [COORD_W-1:0] r_lo, r_hi, c_lo, c_hi, j_ext;
  logic signed [COORD_W-1:0] cell_row, cell_col;
  logic [J_W-1:0]            two_r;
  logic                      in_ring, is_last;

  assign two_r = {rad_q, 1'b0};
  assign j_ext = COORD_W'(j_q);
  assign r_lo  = COORD_W'(row_q) - COORD_W'(rad_q);
  assign r_hi  = COORD_W'(row_q) + COORD_W'(rad_q);
  assign c_lo  = COORD_W'(col_q) - COORD_W'(rad_q);
  assign c_hi  = COORD_W'(col_q) + COORD_W'(rad_q);

  always_comb begin
    cell_row = r_lo;
    cell_col = c_lo;
    in_ring  = 1'b0;
    is_last  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
      end
      ST_ROWS: begin
        // Top and bottom rows, full width including the corners.
        in_ring  = 1'b1;
        cell_row = side_q ? r_hi : r_lo;
        cell_col = c_lo + j_ext;
        is_last  = (rad_q == '0);
      end
      ST_COLS: begin
        // Left and right columns without their corners.
        in_ring  = 1'b1;
        cell_row = r_lo + j_ext;
        cell_col = side_q ? c_hi : c_lo;
        is_last  = side_q && (j_q == two_r - J_W'(1));
      end
      default: begin
      end
    endcase
  end

  assign req_o.valid = in_ring;
  assign req_o.inb   = !cell_row[COORD_W-1] && !cell_col[COORD_W-1] &&
                       (cell_row < COORD_W'(eff_rows_i)) &&
                       (cell_col < COORD_W'(eff_cols_i));
  assign req_o.first = (state_q == ST_ROWS) && (j_q == '0) && !side_q;
  assign req_o.last  = is_last;
  assign rd_addr_o   = {cell_row[AW-1:0], cell_col[AW-1:0]};
  assign busy_o      = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      rad_q   <= '0;
      side_q  <= 1'b0;
      j_q     <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_ROWS;
            row_q   <= row_i;
            col_q   <= col_i;
            rad_q   <= radius_i;
            j_q     <= '0;
            side_q  <= 1'b0;
          end
        end
        ST_ROWS: begin
          if (rad_q == '0) begin
            state_q <= ST_IDLE;
          end else if (!side_q) begin
            side_q <= 1'b1;
          end else begin
            side_q <= 1'b0;
            if (j_q == two_r) begin
              state_q <= ST_COLS;
              j_q     <= J_W'(1);
            end else begin
              j_q <= j_q + J_W'(1);
            end
          end
        end
        ST_COLS: begin
          if (!side_q) begin
            side_q <= 1'b1;
          end else begin
            side_q <= 1'b0;
            if (is_last) begin
              state_q <= ST_IDLE;
            end else begin
              j_q <= j_q + J_W'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The cycle after the last cell nothing more is issued.
  a_quiet_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.valid && req_o.last |=> !req_o.valid)
    else $error("ring walker issued a cell after the last one");

  // A started query issues its first cell in the next cycle.
  a_first_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> req_o.valid && req_o.first)
    else $error("ring walker did not begin with the first cell");
`endif

endmodule

// ===== rtl/mrs_accum.sv =====
// ----------------------------------------------------------------------------
// mrs_accum
// Adds the read samples of a ring, saturates, and holds the result item.
// ----------------------------------------------------------------------------
module mrs_accum import mrs_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ring_req_t              req_i,
  input  logic [SAMPLE_BITS-1:0] rdata_i,
  input  logic                   m_ready_i,
  output logic                   m_valid_o,
  output logic [OUT_W-1:0]       m_data_o,
  output logic                   busy_o
);

  // Headroom for up to 248 cells, never narrower than the result plus a sign.
  localparam int ACC_W = (SAMPLE_BITS + 9 > OUT_W + 1) ? SAMPLE_BITS + 9 : OUT_W + 1;
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(SUM_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(SUM_MIN);

  ring_req_t               req_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] term, sat;
  logic                    done_q, done_d;
  logic                    m_valid_q, m_valid_d;
  logic [OUT_W-1:0]        m_data_q, m_data_d;
  logic                    out_free;

  assign term     = req_q.inb ? ACC_W'($signed(rdata_i)) : '0;
  assign out_free = !m_valid_q || m_ready_i;

  always_comb begin
    if (acc_q > ACC_MAX) begin
      sat = ACC_MAX;
    end else if (acc_q < ACC_MIN) begin
      sat = ACC_MIN;
    end else begin
      sat = acc_q;
    end
  end

  always_comb begin
    acc_d     = acc_q;
    done_d    = done_q;
    m_valid_d = m_valid_q && !m_ready_i;
    m_data_d  = m_data_q;
    if (req_q.valid) begin
      acc_d = (req_q.first ? '0 : acc_q) + term;
      if (req_q.last) begin
        done_d = 1'b1;
      end
    end
    if (done_q && out_free) begin
      done_d    = 1'b0;
      m_valid_d = 1'b1;
      m_data_d  = sat[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q     <= '0;
      done_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      req_q     <= req_i;
      done_q    <= done_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    m_data_q <= m_data_d;
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign busy_o    = req_q.valid || done_q;

`ifndef SYNTH
  // A finished sum is never overtaken by cells of another query.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_q && req_q.valid))
    else $error("ring cells arrived while a sum waited for hand-over");

  // A result item appears only from a finished sum.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(done_q))
    else $error("result item raised without a finished sum");
`endif

endmodule

// ===== rtl/matrix_ring_sum.sv =====
// ----------------------------------------------------------------------------
// matrix_ring_sum
// Stores a matrix of signed samples and returns ring sums around a cell.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Accepted when                  Carries
//  s_axis    in         s_axis_tvalid & s_axis_tready  write or query item
//  m_axis    out        m_axis_tvalid & m_axis_tready  ring sum of a query
//  cfg       in         cfg_we_i                       num_rows, num_cols, radius
//
// A write item produces no result. A query with radius R
// reads n cells, n = 8*R (one cell for radius 0), from the sample memory
// through its single read port, one per cycle, and its result item is loaded
// into the output register after the last read passes the request register
// and the done flag, once that is free; items are taken after the hand-over.
// Reset returns the configuration to its defaults and clears the control
// state; the sample memory is not cleared and holds undefined data until
// written. A result that waits in the output register does not stop write
// items or the next query's walk; only the hand-over of the next sum waits
// for the register to empty, and input items stall while it waits.
//
module matrix_ring_sum import mrs_pkg::*; #(
  parameter int DIM         = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [4:0] row, [9:5] col, [25:10] value, [31:26] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] action
  input  logic                   s_axis_tuser,

  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [23:0] ring_sum
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,

  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  // Row and column index bits of the store; entry address is {row, col}.
  localparam int AW     = $clog2(DIM);
  localparam int ADDR_W = 2 * AW;
  localparam int EXT_W  = (SAMPLE_BITS > VALUE_W) ? SAMPLE_BITS : VALUE_W;

  logic [SIZE_W-1:0]   num_rows_q;
  logic [SIZE_W-1:0]   num_cols_q;
  logic [RADIUS_W-1:0] radius_q;

  logic [EFF_W-1:0]    eff_rows, eff_cols;

  logic [IDX_W-1:0]          in_row, in_col;
  logic signed [VALUE_W-1:0] in_value;
  logic signed [EXT_W-1:0]   value_ext;
  logic [COORD_W-1:0]        wr_row_ext, wr_col_ext;

  logic                   in_accept, query_start;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr, rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;

  ring_req_t          req;
  logic               gen_busy, acc_busy;
  logic [OUT_W-1:0]   ring_sum;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= RESET_NUM_ROWS;
      num_cols_q <= RESET_NUM_COLS;
      radius_q   <= RESET_RADIUS;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_NUM_ROWS: num_rows_q <= cfg_wdata_i[SIZE_W-1:0];
        REG_NUM_COLS: num_cols_q <= cfg_wdata_i[SIZE_W-1:0];
        REG_RADIUS:   radius_q   <= cfg_wdata_i[RADIUS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sizes larger than the store act as the store's dimension.
  assign eff_rows = (EFF_W'(num_rows_q) > EFF_W'(DIM)) ? EFF_W'(DIM) : EFF_W'(num_rows_q);
  assign eff_cols = (EFF_W'(num_cols_q) > EFF_W'(DIM)) ? EFF_W'(DIM) : EFF_W'(num_cols_q);

  // Unpack the input item.
  assign in_row   = s_axis_tdata[IDX_W-1:0];
  assign in_col   = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_value = s_axis_tdata[2*IDX_W+VALUE_W-1:2*IDX_W];

  // One item at a time: a query walk and its sum hand-over block new items.
  assign s_axis_tready = !gen_busy && !acc_busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign query_start   = in_accept && (s_axis_tuser == ACT_QUERY);

  // A write outside the configured size is dropped. The sample keeps its low
  // SAMPLE_BITS bits, sign-extended first where the store is wider.
  assign wr_row_ext = COORD_W'(in_row);
  assign wr_col_ext = COORD_W'(in_col);
  assign value_ext  = EXT_W'(in_value);
  assign wr_en      = in_accept && (s_axis_tuser == ACT_WRITE) &&
                      (EFF_W'(in_row) < eff_rows) && (EFF_W'(in_col) < eff_cols);
  assign wr_addr    = {wr_row_ext[AW-1:0], wr_col_ext[AW-1:0]};

  mrs_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (value_ext[SAMPLE_BITS-1:0]),
    .re_i    (req.valid),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  mrs_ring_gen #(
    .AW (AW)
  ) u_ring_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (query_start),
    .row_i      (in_row),
    .col_i      (in_col),
    .radius_i   (radius_q),
    .eff_rows_i (eff_rows),
    .eff_cols_i (eff_cols),
    .rd_addr_o  (rd_addr),
    .req_o      (req),
    .busy_o     (gen_busy)
  );

  mrs_accum #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rdata_i   (rd_data),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (ring_sum),
    .busy_o    (acc_busy)
  );

  assign m_axis_tdata = OUT_TDATA_W'(ring_sum);

`ifndef SYNTH
  // The store is never written while a ring walk reads it.
  a_no_write_during_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !req.valid)
    else $error("sample write overlapped a ring walk");

  // A query start is followed by its first cell read, not by a write.
  a_query_reads_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_start |=> req.valid && !wr_en)
    else $error("query start not followed by a ring read");

  // A query's last cell, once registered in the accumulator, keeps items from being taken.
  a_hold_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.last |=> !s_axis_tready)
    else $error("item accepted before the sum was handed over");
`endif

endmodule
